### sv/bsc_pkg.sv
// ---------------------------------------------------------------------------
// bsc_pkg
// Shared types and constants of the bounding sphere slot cache.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsc_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned RADIUS_W = 23;
  localparam int unsigned BATCH_W  = 16;
  localparam int unsigned STATUS_W = 3;

  // Squared radius difference width
  localparam int unsigned RSQ_W = 2 * RADIUS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_FILL   = 2'd3
  } bsc_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_BAD_INDEX     = 3'd1,
    ST_ADD_USED      = 3'd2,
    ST_REMOVE_UNUSED = 3'd3,
    ST_UPDATE_UNUSED = 3'd4
  } bsc_status_e;

  // Control bits of one item as it travels down the pipeline
  typedef struct packed {
    bsc_cmd_e cmd;
    logic     bad;       // slot index at or above the slot count
    logic     tracked;   // slot takes part in the running maximum
    logic     batch_nz;  // fill report with a nonzero batch count
  } bsc_item_t;

endpackage

### sv/bounding_sphere_slot_cache_unit.sv
// ---------------------------------------------------------------------------
// bounding_sphere_slot_cache_unit
// Slot table of cached bounding spheres with add, remove, update and fill.
// ---------------------------------------------------------------------------
// An item is taken each cycle unless the block stalls, and its result reaches
// the output register through the pipeline: the slot read is registered at
// acceptance, stage B registers the squared distances, and the test and
// write-back happen as the item moves into the output register.
// An item naming the same slot as either of the two items ahead of it waits
// until that item has written back.
// After reset the slot memory is zeroed by a clearing pass over every slot,
// during which no item is taken.
`timescale 1ns / 1ps

module bounding_sphere_slot_cache_unit #(
  parameter int unsigned SLOT_COUNT    = 512,
  parameter int unsigned TRACKED_SLOTS = 8,
  parameter int unsigned COORD_BITS    = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [bsc_pkg::CMD_W-1:0]           cmd_i,
  input  logic [bsc_pkg::SLOT_W-1:0]          slot_i,
  input  logic signed [bsc_pkg::POS_W-1:0]    pos_x_i,
  input  logic signed [bsc_pkg::POS_W-1:0]    pos_y_i,
  input  logic signed [bsc_pkg::POS_W-1:0]    pos_z_i,
  input  logic [bsc_pkg::RADIUS_W-1:0]        radius_i,
  input  logic [bsc_pkg::BATCH_W-1:0]         batch_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bsc_pkg::STATUS_W-1:0]        status_o,
  output logic                                dirty_o,
  output logic [bsc_pkg::RADIUS_W-1:0]        max_radius_o
);

  localparam int unsigned CB      = COORD_BITS;
  localparam int unsigned AW      = $clog2(SLOT_COUNT);
  localparam int unsigned ENTRY_W = 3 * CB + 3 + bsc_pkg::RADIUS_W;
  localparam int unsigned SLW     = bsc_pkg::SLOT_W + 1;
  localparam logic [SLW-1:0] SLOT_LIMIT    = SLW'(SLOT_COUNT);
  localparam logic [SLW-1:0] TRACKED_LIMIT = SLW'(TRACKED_SLOTS);
  localparam logic [AW-1:0]  LAST_SLOT     = AW'(SLOT_COUNT - 1);

  // Clearing pass
  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;

  // Stage A: item registered alongside the slot read
  logic                          a_valid_q;
  bsc_pkg::bsc_item_t            a_item_q;
  logic [bsc_pkg::SLOT_W-1:0]    a_slot_q;
  logic [CB-1:0]                 a_px_q, a_py_q, a_pz_q;
  logic [bsc_pkg::RADIUS_W-1:0]  a_r_q;

  // Stage B: products ready, entry copied
  logic                          b_valid_q;
  bsc_pkg::bsc_item_t            b_item_q;
  logic [bsc_pkg::SLOT_W-1:0]    b_slot_q;
  logic [CB-1:0]                 b_px_q, b_py_q, b_pz_q;
  logic [bsc_pkg::RADIUS_W-1:0]  b_r_q;
  logic [ENTRY_W-1:0]            b_ent_q;

  // Output register
  logic                          out_valid_q;
  bsc_pkg::bsc_status_e          out_status_q;
  logic                          out_dirty_q;
  logic [bsc_pkg::RADIUS_W-1:0]  largest_q, largest_d;

  logic                          out_free, b_adv, b_free, a_adv, a_free;
  logic                          hazard, accept;
  bsc_pkg::bsc_item_t            in_item;
  logic [ENTRY_W-1:0]            rd_ent;
  logic [2*CB-1:0]               sq_x, sq_y, sq_z;
  logic [bsc_pkg::RSQ_W-1:0]     msq;
  logic                          r_gt;
  logic [ENTRY_W-1:0]            new_ent;
  logic                          b_we;
  bsc_pkg::bsc_status_e          b_status;
  logic                          b_dirty;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [ENTRY_W-1:0]            ram_wdata;

  // Pipeline flow
  assign out_free = !out_valid_q || !out_stall_i;
  assign b_adv    = b_valid_q && out_free;
  assign b_free   = !b_valid_q || b_adv;
  assign a_adv    = a_valid_q && b_free;
  assign a_free   = !a_valid_q || a_adv;

  // Hold an item whose slot is still in flight
  assign hazard = (a_valid_q && (a_slot_q == slot_i)) ||
                  (b_valid_q && (b_slot_q == slot_i));

  assign in_stall_o = clr_busy_q || !a_free || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  // Decode the incoming item
  always_comb begin
    in_item.cmd      = bsc_pkg::bsc_cmd_e'(cmd_i);
    in_item.bad      = {1'b0, slot_i} >= SLOT_LIMIT;
    in_item.tracked  = {1'b0, slot_i} < TRACKED_LIMIT;
    in_item.batch_nz = batch_count_i != '0;
  end

  // Slot memory: write-back or clearing pass
  assign ram_we    = clr_busy_q || (b_adv && b_we);
  assign ram_waddr = clr_busy_q ? clr_idx_q : b_slot_q[AW-1:0];
  assign ram_wdata = clr_busy_q ? '0 : new_ent;

  bsc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (slot_i[AW-1:0]),
    .rdata_o (rd_ent)
  );

  bsc_sq_stage #(
    .CB (CB)
  ) u_sq (
    .clk_i  (clk_i),
    .en_i   (a_adv),
    .ent_i  (rd_ent),
    .px_i   (a_px_q),
    .py_i   (a_py_q),
    .pz_i   (a_pz_q),
    .r_i    (a_r_q),
    .sq_x_o (sq_x),
    .sq_y_o (sq_y),
    .sq_z_o (sq_z),
    .msq_o  (msq),
    .r_gt_o (r_gt)
  );

  bsc_apply #(
    .CB (CB)
  ) u_apply (
    .item_i   (b_item_q),
    .ent_i    (b_ent_q),
    .px_i     (b_px_q),
    .py_i     (b_py_q),
    .pz_i     (b_pz_q),
    .r_i      (b_r_q),
    .sq_x_i   (sq_x),
    .sq_y_i   (sq_y),
    .sq_z_i   (sq_z),
    .msq_i    (msq),
    .r_gt_i   (r_gt),
    .ent_o    (new_ent),
    .we_o     (b_we),
    .status_o (b_status),
    .dirty_o  (b_dirty)
  );

  // Running maximum over updates of tracked slots
  always_comb begin
    largest_d = largest_q;
    if (b_adv && (b_item_q.cmd == bsc_pkg::CMD_UPDATE) && !b_item_q.bad &&
        b_item_q.tracked && (b_r_q > largest_q)) begin
      largest_d = b_r_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      largest_q   <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
        if (clr_idx_q == LAST_SLOT) begin
          clr_busy_q <= 1'b0;
        end
      end
      a_valid_q   <= accept || (a_valid_q && !a_adv);
      b_valid_q   <= a_adv || (b_valid_q && !b_adv);
      out_valid_q <= b_adv || (out_valid_q && out_stall_i);
      largest_q   <= largest_d;
    end
  end

  // Stage A payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_item_q <= in_item;
      a_slot_q <= slot_i;
      a_px_q   <= CB'($unsigned(pos_x_i));
      a_py_q   <= CB'($unsigned(pos_y_i));
      a_pz_q   <= CB'($unsigned(pos_z_i));
      a_r_q    <= radius_i;
    end
  end

  // Stage B payload
  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_item_q <= a_item_q;
      b_slot_q <= a_slot_q;
      b_px_q   <= a_px_q;
      b_py_q   <= a_py_q;
      b_pz_q   <= a_pz_q;
      b_r_q    <= a_r_q;
      b_ent_q  <= rd_ent;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      out_status_q <= b_status;
      out_dirty_q  <= b_dirty;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign dirty_o      = out_dirty_q;
  assign max_radius_o = largest_q;

  // No item is taken while the memory is cleared
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !clr_busy_q)
    else $error("item accepted during clearing pass");

  // Write-back never collides with the clearing pass
  a_no_wb_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !b_valid_q && !a_valid_q)
    else $error("pipeline busy during clearing pass");

  // Two items in flight never share a slot
  a_no_slot_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && b_valid_q) |-> (a_slot_q != b_slot_q))
    else $error("same slot in two pipeline stages");

  // A bad index never reports dirty
  a_bad_not_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == bsc_pkg::ST_BAD_INDEX)) |-> !out_dirty_q)
    else $error("bad index item reports dirty");

  // The running maximum never falls
  a_max_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> (largest_q >= $past(largest_q)))
    else $error("running maximum decreased");

endmodule

### sv/bsc_ram.sv
// ---------------------------------------------------------------------------
// bsc_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/bsc_sq_stage.sv
// ---------------------------------------------------------------------------
// bsc_sq_stage
// Squared axis distances and squared radius margin, registered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_sq_stage #(
  parameter int unsigned CB = 24
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [3*CB+3+bsc_pkg::RADIUS_W-1:0] ent_i,
  input  logic [CB-1:0]                px_i,
  input  logic [CB-1:0]                py_i,
  input  logic [CB-1:0]                pz_i,
  input  logic [bsc_pkg::RADIUS_W-1:0] r_i,
  output logic [2*CB-1:0]              sq_x_o,
  output logic [2*CB-1:0]              sq_y_o,
  output logic [2*CB-1:0]              sq_z_o,
  output logic [bsc_pkg::RSQ_W-1:0]    msq_o,
  output logic                         r_gt_o
);

  typedef struct packed {
    logic                         used;
    logic                         dirty;
    logic                         batches;
    logic [CB-1:0]                cx;
    logic [CB-1:0]                cy;
    logic [CB-1:0]                cz;
    logic [bsc_pkg::RADIUS_W-1:0] rad;
  } ent_t;

  ent_t                         ent;
  logic [CB:0]                  dx, dy, dz;
  logic [CB-1:0]                mx, my, mz;
  logic [bsc_pkg::RADIUS_W-1:0] margin;
  logic [2*CB-1:0]              sq_x_q, sq_y_q, sq_z_q;
  logic [bsc_pkg::RSQ_W-1:0]    msq_q;
  logic                         r_gt_q;

  assign ent = ent_t'(ent_i);

  // Signed differences, one bit wider than a coordinate
  assign dx = {px_i[CB-1], px_i} - {ent.cx[CB-1], ent.cx};
  assign dy = {py_i[CB-1], py_i} - {ent.cy[CB-1], ent.cy};
  assign dz = {pz_i[CB-1], pz_i} - {ent.cz[CB-1], ent.cz};

  // Magnitudes always fit a coordinate width
  assign mx = dx[CB] ? CB'(-dx) : dx[CB-1:0];
  assign my = dy[CB] ? CB'(-dy) : dy[CB-1:0];
  assign mz = dz[CB] ? CB'(-dz) : dz[CB-1:0];

  // Margin is only used when the object fits the cached radius
  assign margin = ent.rad - r_i;

  // Register the products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_x_q <= {{CB{1'b0}}, mx} * {{CB{1'b0}}, mx};
      sq_y_q <= {{CB{1'b0}}, my} * {{CB{1'b0}}, my};
      sq_z_q <= {{CB{1'b0}}, mz} * {{CB{1'b0}}, mz};
      msq_q  <= {{bsc_pkg::RADIUS_W{1'b0}}, margin} * {{bsc_pkg::RADIUS_W{1'b0}}, margin};
      r_gt_q <= r_i > ent.rad;
    end
  end

  assign sq_x_o = sq_x_q;
  assign sq_y_o = sq_y_q;
  assign sq_z_o = sq_z_q;
  assign msq_o  = msq_q;
  assign r_gt_o = r_gt_q;

endmodule

### sv/bsc_apply.sv
// ---------------------------------------------------------------------------
// bsc_apply
// Staleness test and next slot entry for one item.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bsc_apply #(
  parameter int unsigned CB = 24
) (
  input  bsc_pkg::bsc_item_t                  item_i,
  input  logic [3*CB+3+bsc_pkg::RADIUS_W-1:0] ent_i,
  input  logic [CB-1:0]                       px_i,
  input  logic [CB-1:0]                       py_i,
  input  logic [CB-1:0]                       pz_i,
  input  logic [bsc_pkg::RADIUS_W-1:0]        r_i,
  input  logic [2*CB-1:0]                     sq_x_i,
  input  logic [2*CB-1:0]                     sq_y_i,
  input  logic [2*CB-1:0]                     sq_z_i,
  input  logic [bsc_pkg::RSQ_W-1:0]           msq_i,
  input  logic                                r_gt_i,
  output logic [3*CB+3+bsc_pkg::RADIUS_W-1:0] ent_o,
  output logic                                we_o,
  output bsc_pkg::bsc_status_e                status_o,
  output logic                                dirty_o
);

  localparam int unsigned SUM_W = 2 * CB + 2;
  localparam int unsigned CMP_W = (SUM_W > bsc_pkg::RSQ_W) ? SUM_W : bsc_pkg::RSQ_W;

  typedef struct packed {
    logic                         used;
    logic                         dirty;
    logic                         batches;
    logic [CB-1:0]                cx;
    logic [CB-1:0]                cy;
    logic [CB-1:0]                cz;
    logic [bsc_pkg::RADIUS_W-1:0] rad;
  } ent_t;

  ent_t             ent;
  ent_t             nxt;
  logic [SUM_W-1:0] d2;
  logic             stale;

  assign ent = ent_t'(ent_i);

  // Squared distance against squared margin
  assign d2    = SUM_W'(sq_x_i) + SUM_W'(sq_y_i) + SUM_W'(sq_z_i);
  assign stale = r_gt_i || (CMP_W'(d2) > CMP_W'(msq_i)) || !ent.batches;

  // Build the next entry and the status
  always_comb begin
    nxt      = ent;
    status_o = bsc_pkg::ST_OK;
    we_o     = 1'b1;
    case (item_i.cmd)
      bsc_pkg::CMD_ADD: begin
        if (ent.used) begin
          status_o = bsc_pkg::ST_ADD_USED;
        end
        nxt.rad     = r_i;
        nxt.batches = 1'b0;
        nxt.used    = 1'b1;
      end
      bsc_pkg::CMD_REMOVE: begin
        if (!ent.used) begin
          status_o = bsc_pkg::ST_REMOVE_UNUSED;
        end
        nxt.dirty = 1'b0;
        nxt.cx    = '0;
        nxt.cy    = '0;
        nxt.cz    = '0;
        nxt.rad   = '0;
        nxt.used  = 1'b0;
      end
      bsc_pkg::CMD_UPDATE: begin
        if (!ent.used) begin
          status_o = bsc_pkg::ST_UPDATE_UNUSED;
        end
        nxt.dirty = stale;
        if (stale) begin
          nxt.cx = px_i;
          nxt.cy = py_i;
          nxt.cz = pz_i;
        end
      end
      bsc_pkg::CMD_FILL: begin
        nxt.batches = item_i.batch_nz;
      end
      default: begin
      end
    endcase
    // A bad index changes nothing
    if (item_i.bad) begin
      status_o = bsc_pkg::ST_BAD_INDEX;
      we_o     = 1'b0;
    end
  end

  assign ent_o   = nxt;
  assign dirty_o = item_i.bad ? 1'b0 : nxt.dirty;

endmodule

### verif/bounding_sphere_slot_cache_unit_tb.sv
// ---------------------------------------------------------------------------
// bounding_sphere_slot_cache_unit_tb
// Self-checking bench for the bounding sphere slot cache. A short table of
// directed items covers the commands, the status codes, the exact
// containment boundary and the coordinate extremes. Random slot lifecycles
// follow: add, fill, updates around the cached centre, and removal. Every
// result is compared with a slot table kept in step with the accepted items or typed row results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bounding_sphere_slot_cache_unit_tb;

  localparam int unsigned CMD_W         = bsc_pkg::CMD_W;
  localparam int unsigned SLOT_W        = bsc_pkg::SLOT_W;
  localparam int unsigned POS_W         = bsc_pkg::POS_W;
  localparam int unsigned RADIUS_W      = bsc_pkg::RADIUS_W;
  localparam int unsigned BATCH_W       = bsc_pkg::BATCH_W;
  localparam int unsigned STATUS_W      = bsc_pkg::STATUS_W;
  localparam int unsigned SLOT_COUNT    = 512;
  localparam int unsigned TRACKED_SLOTS = 8;
  localparam int unsigned COORD_BITS    = 24;
  localparam int unsigned RANDOM_ITEMS  = 400;
  localparam int unsigned HOLD_AT       = 60;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned TIMEOUT_NS    = 400_000;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;

  typedef struct {
    bsc_pkg::bsc_cmd_e         cmd;
    logic [SLOT_W-1:0]         slot;
    logic signed [POS_W-1:0]   pos_x;
    logic signed [POS_W-1:0]   pos_y;
    logic signed [POS_W-1:0]   pos_z;
    logic [RADIUS_W-1:0]       radius;
    logic [BATCH_W-1:0]        batches;
  } cache_item_t;

  typedef struct {
    bsc_pkg::bsc_status_e      status;
    logic                      dirty;
    logic [RADIUS_W-1:0]       max_radius;
  } cache_result_t;

  typedef struct {
    cache_item_t               it;
    bit                        known;
    cache_result_t             res;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CMD_W-1:0]            cmd = '0;
  logic [SLOT_W-1:0]           slot = '0;
  logic signed [POS_W-1:0]     pos_x = '0;
  logic signed [POS_W-1:0]     pos_y = '0;
  logic signed [POS_W-1:0]     pos_z = '0;
  logic [RADIUS_W-1:0]         radius = '0;
  logic [BATCH_W-1:0]          batch_count = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [STATUS_W-1:0]         status;
  logic                        dirty;
  logic [RADIUS_W-1:0]         max_radius;

  // Shadow slot table
  bit                          slot_used [SLOT_COUNT];
  bit                          slot_dirty [SLOT_COUNT];
  logic signed [POS_W-1:0]     centre_x [SLOT_COUNT];
  logic signed [POS_W-1:0]     centre_y [SLOT_COUNT];
  logic signed [POS_W-1:0]     centre_z [SLOT_COUNT];
  logic [RADIUS_W-1:0]         sphere_radius [SLOT_COUNT];
  bit                          batches_present [SLOT_COUNT];
  logic [RADIUS_W-1:0]         top_radius = '0;

  cache_result_t               pending_results[$];
  stim_row_t                   stim_rows[$];
  bit                          no_idle = 1'b0;
  int unsigned                 mismatch_count = 0;
  int unsigned                 results_checked = 0;
  int unsigned                 items_sent = 0;
  int unsigned                 cmd_count [4];
  int unsigned                 stale_updates = 0;
  int unsigned                 kept_updates = 0;
  int unsigned                 bad_slots = 0;

  bounding_sphere_slot_cache_unit #(
    .SLOT_COUNT   (SLOT_COUNT),
    .TRACKED_SLOTS(TRACKED_SLOTS),
    .COORD_BITS   (COORD_BITS)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .slot_i       (slot),
    .pos_x_i      (pos_x),
    .pos_y_i      (pos_y),
    .pos_z_i      (pos_z),
    .radius_i     (radius),
    .batch_count_i(batch_count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .dirty_o      (dirty),
    .max_radius_o (max_radius)
  );

  // Free-running clock, 8 ns period
  always #4 clk = ~clk;

  // Advance the slot table by one item and return the result it causes
  function automatic cache_result_t predict_slot_step(cache_item_t it);
    cache_result_t res;
    int unsigned   s;
    longint        dx, dy, dz, d2, m;
    bit            stale;
    res.status = bsc_pkg::ST_OK;
    res.dirty  = 1'b0;
    res.max_radius = top_radius;
    if (it.slot >= SLOT_COUNT) begin
      res.status = bsc_pkg::ST_BAD_INDEX;
      bad_slots++;
      return res;
    end
    s = it.slot;
    case (it.cmd)
      bsc_pkg::CMD_ADD: begin
        if (slot_used[s]) res.status = bsc_pkg::ST_ADD_USED;
        sphere_radius[s]   = it.radius;
        batches_present[s] = 1'b0;
        slot_used[s]       = 1'b1;
      end
      bsc_pkg::CMD_REMOVE: begin
        if (!slot_used[s]) res.status = bsc_pkg::ST_REMOVE_UNUSED;
        slot_dirty[s]    = 1'b0;
        centre_x[s]      = '0;
        centre_y[s]      = '0;
        centre_z[s]      = '0;
        sphere_radius[s] = '0;
        slot_used[s]     = 1'b0;
      end
      bsc_pkg::CMD_UPDATE: begin
        if (!slot_used[s]) res.status = bsc_pkg::ST_UPDATE_UNUSED;
        if (it.radius > sphere_radius[s]) begin
          stale = 1'b1;
        end else begin
          dx = longint'(it.pos_x) - longint'(centre_x[s]);
          dy = longint'(it.pos_y) - longint'(centre_y[s]);
          dz = longint'(it.pos_z) - longint'(centre_z[s]);
          d2 = dx * dx + dy * dy + dz * dz;
          m  = longint'(sphere_radius[s]) - longint'(it.radius);
          stale = d2 > m * m;
        end
        if (!batches_present[s]) stale = 1'b1;
        slot_dirty[s] = stale;
        if (stale) begin
          centre_x[s] = it.pos_x;
          centre_y[s] = it.pos_y;
          centre_z[s] = it.pos_z;
          stale_updates++;
        end else begin
          kept_updates++;
        end
        if (s < TRACKED_SLOTS && it.radius > top_radius) top_radius = it.radius;
      end
      default: begin
        batches_present[s] = (it.batches != '0);
      end
    endcase
    res.dirty      = slot_dirty[s];
    res.max_radius = top_radius;
    return res;
  endfunction

  // Append one directed row; typed results apply only where known is set
  function automatic void add_row(bsc_pkg::bsc_cmd_e c, int unsigned s, int x, int y,
                                  int z, int unsigned r, int unsigned b, bit known,
                                  bsc_pkg::bsc_status_e st, bit d, int unsigned mx);
    stim_row_t row;
    row.it.cmd     = c;
    row.it.slot    = s[SLOT_W-1:0];
    row.it.pos_x   = x[POS_W-1:0];
    row.it.pos_y   = y[POS_W-1:0];
    row.it.pos_z   = z[POS_W-1:0];
    row.it.radius  = r[RADIUS_W-1:0];
    row.it.batches = b[BATCH_W-1:0];
    row.known      = known;
    row.res.status = st;
    row.res.dirty  = d;
    row.res.max_radius = mx[RADIUS_W-1:0];
    stim_rows.push_back(row);
  endfunction

  // Fill every field with noise
  function automatic cache_item_t random_fields();
    cache_item_t it;
    it.cmd     = bsc_pkg::bsc_cmd_e'(CMD_W'($urandom_range(0, 3)));
    it.slot    = SLOT_W'($urandom);
    it.pos_x   = POS_W'($urandom);
    it.pos_y   = POS_W'($urandom);
    it.pos_z   = POS_W'($urandom);
    it.radius  = RADIUS_W'($urandom);
    it.batches = BATCH_W'($urandom);
    return it;
  endfunction

  // Mostly low slots around the tracked ones and the top of the table, rarely a bad index
  function automatic int unsigned pick_slot();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return $urandom_range(0, 11);
    if (p < 85) return $urandom_range(SLOT_COUNT - 12, SLOT_COUNT - 1);
    if (p < 95) return $urandom_range(0, SLOT_COUNT - 1);
    return $urandom_range(SLOT_COUNT, 1023);
  endfunction

  // Move a coordinate by up to half the spread either way, wrapping at the field
  function automatic logic signed [POS_W-1:0] nudge(logic signed [POS_W-1:0] c,
                                                    int unsigned spread);
    int off;
    off = (int'($urandom_range(0, 2 * spread)) - int'(spread)) / 2;
    return POS_W'(c + off);
  endfunction

  // Update that lands near the cached centre, mostly with a radius under the cached one
  function automatic cache_item_t near_update(int unsigned s);
    cache_item_t it;
    int unsigned spread;
    it = random_fields();
    it.cmd  = bsc_pkg::CMD_UPDATE;
    it.slot = s[SLOT_W-1:0];
    if (s >= SLOT_COUNT) return it;
    spread = (sphere_radius[s] == 0) ? 64 : sphere_radius[s];
    if (spread > (1 << 20)) spread = 1 << 20;
    it.pos_x = nudge(centre_x[s], spread);
    it.pos_y = nudge(centre_y[s], spread);
    it.pos_z = nudge(centre_z[s], spread);
    if ($urandom_range(0, 9) < 8) begin
      it.radius = RADIUS_W'($urandom_range(0, sphere_radius[s] / 2));
    end
    return it;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(cache_item_t it, bit known, cache_result_t typed);
    int unsigned   gap;
    cache_result_t exp_res;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    cmd         = it.cmd;
    slot        = it.slot;
    pos_x       = it.pos_x;
    pos_y       = it.pos_y;
    pos_z       = it.pos_z;
    radius      = it.radius;
    batch_count = it.batches;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_stall);
    exp_res = predict_slot_step(it);
    if (known) exp_res = typed;
    pending_results.push_back(exp_res);
    cmd_count[it.cmd]++;
    items_sent++;
  endtask

  // Receiver: random stall per item, one long hold to back the block up
  initial begin
    int unsigned   n;
    bit            held;
    cache_result_t exp_res;
    held = 1'b0;
    forever begin
      if (!held && results_checked >= HOLD_AT) begin
        held = 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 5);
      end
      repeat (n) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (pending_results.size() == 0) begin
        $error("result with no item pending: status %0d dirty %0d", status, dirty);
        mismatch_count++;
      end else begin
        exp_res = pending_results.pop_front();
        results_checked++;
        if (status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status);
          mismatch_count++;
        end
        if (dirty !== exp_res.dirty) begin
          $error("dirty: expected %0d, actual %0d", exp_res.dirty, dirty);
          mismatch_count++;
        end
        if (max_radius !== exp_res.max_radius) begin
          $error("max_radius: expected %0d, actual %0d", exp_res.max_radius, max_radius);
          mismatch_count++;
        end
      end
    end
  end

  // Hard stop if the run hangs
  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    cache_item_t   it;
    cache_result_t none;
    int unsigned   s, k, random_sent;
    none.status = bsc_pkg::ST_OK;
    none.dirty  = 1'b0;
    none.max_radius = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_used[i] = 1'b0;
      slot_dirty[i] = 1'b0;
      centre_x[i] = '0;
      centre_y[i] = '0;
      centre_z[i] = '0;
      sphere_radius[i] = '0;
      batches_present[i] = 1'b0;
    end
    for (int i = 0; i < 4; i++) cmd_count[i] = 0;

    // Hold reset, then release it on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed rows: use-state flags, containment boundary, extremes
    add_row(bsc_pkg::CMD_ADD, 0, 0, 0, 0, 100, 0, 1, bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_ADD, 0, 0, 0, 0, 1000, 0, 1, bsc_pkg::ST_ADD_USED, 0, 0);
    // no batches yet: always stale
    add_row(bsc_pkg::CMD_UPDATE, 0, 0, 0, 0, 0, 0, 1, bsc_pkg::ST_OK, 1, 0);
    add_row(bsc_pkg::CMD_FILL, 0, 0, 0, 0, 0, 16'hFFFF, 1, bsc_pkg::ST_OK, 1, 0);
    // distance exactly equals the margin, then one past it
    add_row(bsc_pkg::CMD_UPDATE, 0, 600, 0, 0, 400, 0, 0, bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_UPDATE, 0, 601, 0, 0, 400, 0, 0, bsc_pkg::ST_OK, 0, 0);
    // object radius above the cached radius
    add_row(bsc_pkg::CMD_UPDATE, 0, 601, 0, 0, 1001, 0, 0, bsc_pkg::ST_OK, 0, 0);
    // untracked slot leaves the running maximum alone
    add_row(bsc_pkg::CMD_UPDATE, 8, -1, -1, -1, 5000, 0, 0, bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_FILL, 0, 0, 0, 0, 0, 0, 0, bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_UPDATE, 0, 601, 0, 0, 0, 0, 0, bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 0, bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_REMOVE, 0, 0, 0, 0, 0, 0, 1, bsc_pkg::ST_REMOVE_UNUSED, 0, 1001);
    add_row(bsc_pkg::CMD_UPDATE, 7, 8388607, -8388608, 8388607, RADIUS_MAX, 0, 1,
            bsc_pkg::ST_UPDATE_UNUSED, 1, RADIUS_MAX);
    // bad indexes on every command
    add_row(bsc_pkg::CMD_ADD, 512, 0, 0, 0, 77, 0, 1, bsc_pkg::ST_BAD_INDEX, 0,
            RADIUS_MAX);
    add_row(bsc_pkg::CMD_FILL, 1023, -1, -1, -1, RADIUS_MAX, 16'hFFFF, 1,
            bsc_pkg::ST_BAD_INDEX, 0, RADIUS_MAX);
    add_row(bsc_pkg::CMD_UPDATE, 1023, -8388608, -8388608, -8388608, RADIUS_MAX,
            16'hFFFF, 1, bsc_pkg::ST_BAD_INDEX, 0, RADIUS_MAX);
    add_row(bsc_pkg::CMD_REMOVE, 777, 0, 0, 0, 0, 0, 1, bsc_pkg::ST_BAD_INDEX, 0,
            RADIUS_MAX);
    // widest coordinates against the largest radius
    add_row(bsc_pkg::CMD_ADD, 511, 0, 0, 0, RADIUS_MAX, 0, 1, bsc_pkg::ST_OK, 0,
            RADIUS_MAX);
    add_row(bsc_pkg::CMD_FILL, 511, 0, 0, 0, 0, 1, 1, bsc_pkg::ST_OK, 0, RADIUS_MAX);
    add_row(bsc_pkg::CMD_UPDATE, 511, 8388607, 8388607, 8388607, 0, 0, 0,
            bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_UPDATE, 511, -8388608, -8388608, -8388608, 0, 0, 0,
            bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_UPDATE, 511, -8388608, -8388608, -8388608, RADIUS_MAX, 0, 0,
            bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_ADD, 7, 0, 0, 0, 50, 0, 0, bsc_pkg::ST_OK, 0, 0);
    add_row(bsc_pkg::CMD_REMOVE, 511, 0, 0, 0, 0, 0, 0, bsc_pkg::ST_OK, 0, 0);
    foreach (stim_rows[i]) send_item(stim_rows[i].it, stim_rows[i].known, stim_rows[i].res);

    // Random part: mostly slot lifecycles, the rest single noisy items
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      no_idle = (random_sent >= 200 && random_sent < 260);
      s = pick_slot();
      if ($urandom_range(0, 99) < 60) begin
        it = random_fields();
        it.cmd  = bsc_pkg::CMD_ADD;
        it.slot = s[SLOT_W-1:0];
        if ($urandom_range(0, 9) != 0) it.radius = RADIUS_W'($urandom_range(256, 65536));
        send_item(it, 1'b0, none);
        it = random_fields();
        it.cmd     = bsc_pkg::CMD_FILL;
        it.slot    = s[SLOT_W-1:0];
        it.batches = BATCH_W'($urandom_range(1, 65535));
        send_item(it, 1'b0, none);
        random_sent += 2;
        k = $urandom_range(2, 6);
        repeat (k) begin
          send_item(near_update(s), 1'b0, none);
          random_sent++;
        end
        // drop batches now and then so the next update must go stale
        if ($urandom_range(0, 3) == 0) begin
          it = random_fields();
          it.cmd     = bsc_pkg::CMD_FILL;
          it.slot    = s[SLOT_W-1:0];
          it.batches = '0;
          send_item(it, 1'b0, none);
          send_item(near_update(s), 1'b0, none);
          random_sent += 2;
        end
        if ($urandom_range(0, 9) < 4) begin
          it = random_fields();
          it.cmd  = bsc_pkg::CMD_REMOVE;
          it.slot = s[SLOT_W-1:0];
          send_item(it, 1'b0, none);
          random_sent++;
        end
      end else begin
        it = random_fields();
        it.slot = s[SLOT_W-1:0];
        k = $urandom_range(0, 99);
        if (k < 20) it.cmd = bsc_pkg::CMD_ADD;
        else if (k < 30) it.cmd = bsc_pkg::CMD_REMOVE;
        else if (k < 75) it.cmd = bsc_pkg::CMD_UPDATE;
        else it.cmd = bsc_pkg::CMD_FILL;
        if (it.cmd == bsc_pkg::CMD_UPDATE && $urandom_range(0, 1) == 1) begin
          it = near_update(s);
        end
        if (it.cmd == bsc_pkg::CMD_FILL && $urandom_range(0, 2) == 0) it.batches = '0;
        send_item(it, 1'b0, none);
        random_sent++;
      end
    end
    no_idle = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;

    // Drain the remaining results, then watch for strays
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: add %0d, remove %0d, update %0d, fill %0d",
             items_sent, cmd_count[bsc_pkg::CMD_ADD], cmd_count[bsc_pkg::CMD_REMOVE],
             cmd_count[bsc_pkg::CMD_UPDATE], cmd_count[bsc_pkg::CMD_FILL]);
    $display("Checked %0d results; updates stale %0d, clean %0d, bad slot indexes %0d",
             results_checked, stale_updates, kept_updates, bad_slots);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
